@@ rtl/core/cse_pkg.sv @@
// Shared constants and types for the counting sort engine.
package cse_pkg;

    // Default key width in bits (signed keys)
    localparam int CSE_KEY_BITS   = 10;
    // Default largest batch that is counted
    localparam int CSE_MAX_ITEMS  = 64;
    // Width of one histogram bin
    localparam int CSE_CNT_BITS   = 7;
    // Default depth of the queue between front and back
    localparam int CSE_FIFO_DEPTH = 4;

    // Per-item flags carried through the queue
    typedef struct packed {
        logic last;      // final key of the batch
        logic counted;   // key goes into the histogram
        logic overflow;  // batch has dropped a key so far
    } cse_qflags_t;

endpackage

@@ rtl/core/cse_in_if.sv @@
// Key input channel: valid/ready handshake with key and last flag.
interface cse_in_if #(
    parameter int KEY_BITS = cse_pkg::CSE_KEY_BITS
);
    logic                       valid;
    logic                       ready;
    logic signed [KEY_BITS-1:0] key;
    logic                       last;

    modport source (output valid, output key, output last, input ready);
    modport sink   (input valid, input key, input last, output ready);
endinterface

@@ rtl/core/cse_out_if.sv @@
// Sorted output channel: valid/ready handshake with value and batch flags.
interface cse_out_if #(
    parameter int KEY_BITS = cse_pkg::CSE_KEY_BITS
);
    logic                       valid;
    logic                       ready;
    logic signed [KEY_BITS-1:0] sorted_value;
    logic                       end_of_batch;
    logic                       dropped;

    modport source (output valid, output sorted_value, output end_of_batch,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input end_of_batch,
                    input dropped, output ready);
endinterface

@@ rtl/core/cse_fifo.sv @@
// Small register queue between the front and back parts.
module cse_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = cse_pkg::CSE_FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slots_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push_fire;
    logic                pop_fire;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

@@ rtl/core/cse_front.sv @@
// Front part: accepts keys, maps them to bins and decides counted or dropped.
module cse_front #(
    parameter int KEY_BITS  = cse_pkg::CSE_KEY_BITS,
    parameter int MAX_ITEMS = cse_pkg::CSE_MAX_ITEMS,
    parameter int QW        = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    cse_in_if.sink        keys,
    input  logic          clear_busy,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [QW-1:0] q_data
);
    localparam int ITEM_BITS = $clog2(MAX_ITEMS + 1);

    logic [ITEM_BITS-1:0] items_reg;
    logic                 ovf_reg;
    logic                 accept;
    logic                 counted;
    logic [ITEM_BITS-1:0] total;
    logic                 ovf;
    logic [KEY_BITS-1:0]  bin;
    cse_pkg::cse_qflags_t flags;

    // No keys while the histogram is being cleared
    assign keys.ready = q_ready && !clear_busy;
    assign accept     = keys.valid && keys.ready;
    assign q_valid    = keys.valid && !clear_busy;

    // Classify: counted while the batch has room
    assign counted = (items_reg < ITEM_BITS'(MAX_ITEMS));
    assign total   = counted ? items_reg + 1'b1 : items_reg;
    assign ovf     = ovf_reg || !counted;

    // Bin index: offset binary, so unsigned order equals signed order
    assign bin = {~keys.key[KEY_BITS-1], keys.key[KEY_BITS-2:0]};

    assign flags.last     = keys.last;
    assign flags.counted  = counted;
    assign flags.overflow = ovf;
    assign q_data         = {flags, total, bin};

    // Batch bookkeeping, restarts after the last key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (keys.last)
            begin
                items_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                items_reg <= total;
                ovf_reg   <= ovf;
            end
        end
    end
endmodule

@@ rtl/core/cse_back.sv @@
// Back part: histogram memory, bin increment pipeline and ascending scan.
module cse_back #(
    parameter int KEY_BITS  = cse_pkg::CSE_KEY_BITS,
    parameter int MAX_ITEMS = cse_pkg::CSE_MAX_ITEMS,
    parameter int QW        = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  logic [QW-1:0] q_data,
    output logic          clear_busy,
    cse_out_if.source     sorted
);
    localparam int NUM_BINS   = 1 << KEY_BITS;
    localparam int CNT_BITS   = cse_pkg::CSE_CNT_BITS;
    localparam int ITEM_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int FLAG_BITS  = $bits(cse_pkg::cse_qflags_t);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Histogram memory
    logic [CNT_BITS-1:0]  counts_mem [NUM_BINS];
    logic [CNT_BITS-1:0]  rd_data_reg;
    logic                 mem_we;
    logic [KEY_BITS-1:0]  mem_waddr;
    logic [CNT_BITS-1:0]  mem_wdata;
    logic [KEY_BITS-1:0]  mem_raddr;

    logic [2:0]           state_reg;
    logic [KEY_BITS-1:0]  idx_reg;
    logic [KEY_BITS-1:0]  lo_reg;
    logic [KEY_BITS-1:0]  hi_reg;
    logic [ITEM_BITS-1:0] total_reg;
    logic                 ovf_reg;
    logic [ITEM_BITS-1:0] emit_cnt_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 fresh_reg;

    // Increment stage and one-deep write forwarding
    logic                 b_valid_reg;
    logic [KEY_BITS-1:0]  b_bin_reg;
    logic                 wr_valid_reg;
    logic [KEY_BITS-1:0]  wr_bin_reg;
    logic [CNT_BITS-1:0]  wr_cnt_reg;
    logic [CNT_BITS-1:0]  b_base;
    logic [CNT_BITS-1:0]  b_new;

    // Output register
    logic                 out_valid_reg;
    logic [KEY_BITS-1:0]  out_value_reg;
    logic                 out_eob_reg;
    logic                 out_drop_reg;

    // Queue entry fields
    cse_pkg::cse_qflags_t q_flags;
    logic [ITEM_BITS-1:0] q_total;
    logic [KEY_BITS-1:0]  q_bin;

    logic [CNT_BITS-1:0]  cur_cnt;
    logic                 slot_free;
    logic                 emit_fire;
    logic                 bin_done;

    assign q_flags = cse_pkg::cse_qflags_t'(q_data[QW-1 -: FLAG_BITS]);
    assign q_total = q_data[KEY_BITS +: ITEM_BITS];
    assign q_bin   = q_data[KEY_BITS-1:0];

    assign q_pop      = (state_reg == ST_LOAD) && q_valid;
    assign clear_busy = (state_reg == ST_CLEAR);

    assign b_base = (wr_valid_reg && (wr_bin_reg == b_bin_reg)) ? wr_cnt_reg : rd_data_reg;
    assign b_new  = b_base + 1'b1;

    assign cur_cnt   = fresh_reg ? rd_data_reg : cnt_reg;
    assign slot_free = !out_valid_reg || sorted.ready;
    assign emit_fire = (state_reg == ST_EMIT) && (cur_cnt != '0) && slot_free;
    assign bin_done  = (state_reg == ST_EMIT) && (cur_cnt == '0);

    // Memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (b_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = b_bin_reg;
            mem_wdata = b_new;
        end
        else if (bin_done)
        begin
            mem_we = 1'b1;
        end
        mem_raddr = (state_reg == ST_LOAD) ? q_bin : idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            counts_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= counts_mem[mem_raddr];
    end

    // Sequencer: clear sweep, load, scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            lo_reg       <= '1;
            hi_reg       <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            emit_cnt_reg <= '0;
            cnt_reg      <= '0;
            fresh_reg    <= 1'b0;
            b_valid_reg  <= 1'b0;
            b_bin_reg    <= '0;
            wr_valid_reg <= 1'b0;
            wr_bin_reg   <= '0;
            wr_cnt_reg   <= '0;
        end
        else
        begin
            wr_valid_reg <= b_valid_reg;
            wr_bin_reg   <= b_bin_reg;
            wr_cnt_reg   <= b_new;
            b_valid_reg  <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == KEY_BITS'(NUM_BINS - 1))
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (q_flags.counted)
                        begin
                            b_valid_reg <= 1'b1;
                            b_bin_reg   <= q_bin;
                            if (q_bin < lo_reg)
                            begin
                                lo_reg <= q_bin;
                            end
                            if (q_bin > hi_reg)
                            begin
                                hi_reg <= q_bin;
                            end
                        end
                        if (q_flags.last)
                        begin
                            total_reg <= q_total;
                            ovf_reg   <= q_flags.overflow;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    // last increment lands in memory at this edge
                    idx_reg   <= lo_reg;
                    state_reg <= (total_reg != '0) ? ST_READ : ST_LOAD;
                    if (total_reg == '0)
                    begin
                        lo_reg <= '1;
                        hi_reg <= '0;
                    end
                end
                ST_READ:
                begin
                    fresh_reg <= 1'b1;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    fresh_reg <= 1'b0;
                    if (cur_cnt != '0)
                    begin
                        if (slot_free)
                        begin
                            cnt_reg      <= cur_cnt - 1'b1;
                            emit_cnt_reg <= emit_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cur_cnt;
                        end
                    end
                    else if (idx_reg == hi_reg)
                    begin
                        // batch finished, back to reset values
                        lo_reg       <= '1;
                        hi_reg       <= '0;
                        emit_cnt_reg <= '0;
                        state_reg    <= ST_LOAD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_eob_reg   <= 1'b0;
            out_drop_reg  <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
            out_value_reg <= {~idx_reg[KEY_BITS-1], idx_reg[KEY_BITS-2:0]};
            out_eob_reg   <= (ITEM_BITS'(emit_cnt_reg + 1'b1) == total_reg);
            out_drop_reg  <= ovf_reg;
        end
        else if (sorted.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sorted.valid        = out_valid_reg;
    assign sorted.sorted_value = signed'(out_value_reg);
    assign sorted.end_of_batch = out_eob_reg;
    assign sorted.dropped      = out_drop_reg;

    // No increment in flight while sweeping or scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_READ || state_reg == ST_EMIT)
        |-> !b_valid_reg)
        else $error("increment pending outside load");

    // Never more results than keys counted in the batch
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (emit_cnt_reg < total_reg))
        else $error("too many results for batch");

    // Scan ends only after every counted key was emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (bin_done && idx_reg == hi_reg) |-> (emit_cnt_reg == total_reg))
        else $error("scan ended with keys left");

    // Scan index stays inside the key range seen
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (idx_reg >= lo_reg && idx_reg <= hi_reg))
        else $error("scan index out of range");
endmodule

@@ rtl/core/counting_sort_engine.sv @@
// Counting sort engine: loads a batch of signed keys, emits them ascending.
// Load: one key per cycle while the queue has room; keys go through an increment stage.
// Scan: after the last key drains, each bin from the smallest to the largest key is read
//   and emits its results, stalling while the output register is full.
// Keys keep entering the queue during a scan until it fills (queue depth FIFO_DEPTH).
// Reset: a clearing pass zeroes all 2^KEY_BITS bins; no keys are taken then.
module counting_sort_engine #(
    parameter int KEY_BITS   = cse_pkg::CSE_KEY_BITS,
    parameter int MAX_ITEMS  = cse_pkg::CSE_MAX_ITEMS,
    parameter int FIFO_DEPTH = cse_pkg::CSE_FIFO_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    cse_in_if.sink    keys,
    cse_out_if.source sorted
);
    localparam int ITEM_BITS = $clog2(MAX_ITEMS + 1);
    localparam int QW        = $bits(cse_pkg::cse_qflags_t) + ITEM_BITS + KEY_BITS;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    logic          clear_busy;

    cse_front #(
        .KEY_BITS  (KEY_BITS),
        .MAX_ITEMS (MAX_ITEMS),
        .QW        (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .keys       (keys),
        .clear_busy (clear_busy),
        .q_valid    (push_valid),
        .q_ready    (push_ready),
        .q_data     (push_data)
    );

    cse_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cse_back #(
        .KEY_BITS  (KEY_BITS),
        .MAX_ITEMS (MAX_ITEMS),
        .QW        (QW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_pop      (pop_ready),
        .q_data     (pop_data),
        .clear_busy (clear_busy),
        .sorted     (sorted)
    );
endmodule

@@ tb/sv/counting_sort_engine_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the counting sort engine with its own sort predictor.
module counting_sort_engine_test;

    localparam int KEY_BITS   = cse_pkg::CSE_KEY_BITS;
    localparam int MAX_ITEMS  = cse_pkg::CSE_MAX_ITEMS;
    localparam int CNT_BITS   = cse_pkg::CSE_CNT_BITS;
    localparam int NUM_BINS   = 1 << KEY_BITS;
    localparam int HALF_BINS  = NUM_BINS / 2;
    localparam int LONG_HOLD  = 400;
    // wait covers a full-range scan over every bin, plus the results
    localparam int END_WAIT   = 2 * NUM_BINS + 2 * MAX_ITEMS + 100;
    localparam int PHASE_KEYS = 70;

    typedef struct {
        logic signed [KEY_BITS-1:0] key;
        logic                       last;
        bit                         pause;   // hold the sender until all results are in
    } load_item_t;

    typedef struct {
        logic signed [KEY_BITS-1:0] value;
        logic                       eob;
        logic                       dropped;
    } sorted_item_t;

    logic clk = 1'b0;
    logic rst_n;

    cse_in_if  #(.KEY_BITS(KEY_BITS)) keys_ch ();
    cse_out_if #(.KEY_BITS(KEY_BITS)) sorted_ch ();

    counting_sort_engine #(
        .KEY_BITS  (KEY_BITS),
        .MAX_ITEMS (MAX_ITEMS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_ch),
        .sorted (sorted_ch)
    );

    always #4 clk = ~clk;

    // stimulus and expectations
    load_item_t   pending[$];
    sorted_item_t sorted_due[$];
    int           errors = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           key_fire = 1'b0;
    bit           hold_go = 1'b0;
    bit           hold_used = 1'b0;
    int           hold_left = 0;

    // histogram shadow and batch state
    logic [CNT_BITS-1:0]        bin_count [NUM_BINS];
    logic signed [KEY_BITS-1:0] lo_key = KEY_BITS'(HALF_BINS - 1);
    logic signed [KEY_BITS-1:0] hi_key = KEY_BITS'(-HALF_BINS);
    int                         loaded = 0;
    bit                         ovf_seen = 1'b0;

    task automatic flag_error(input string msg);
        if (errors < 10)
            $display("%0t: %s", $time, msg);
        errors++;
    endtask

    // count one key; on the last key, emit the batch in ascending order
    task automatic sort_predict(input logic signed [KEY_BITS-1:0] k, input logic lst);
        int           b;
        int           lo_bin;
        int           hi_bin;
        int           made;
        sorted_item_t r;
        made = 0;
        if (loaded < MAX_ITEMS) begin
            b = int'(k) + HALF_BINS;
            bin_count[b] = bin_count[b] + 1'b1;
            if (k < lo_key)
                lo_key = k;
            if (k > hi_key)
                hi_key = k;
            loaded++;
        end
        else
        begin
            ovf_seen = 1'b1;
        end
        if (lst)
        begin
            lo_bin = int'(lo_key) + HALF_BINS;
            hi_bin = int'(hi_key) + HALF_BINS;
            for (b = lo_bin; b <= hi_bin; b++)
            begin
                while (bin_count[b] != 0 && made < MAX_ITEMS)
                begin
                    bin_count[b] = bin_count[b] - 1'b1;
                    made++;
                    r.value   = KEY_BITS'(b - HALF_BINS);
                    r.eob     = (made == loaded);
                    r.dropped = ovf_seen;
                    sorted_due.push_back(r);
                end
            end
            lo_key   = KEY_BITS'(HALF_BINS - 1);
            hi_key   = KEY_BITS'(-HALF_BINS);
            loaded   = 0;
            ovf_seen = 1'b0;
        end
    endtask

    task automatic push_key(input logic signed [KEY_BITS-1:0] k, input logic lst);
        load_item_t it;
        it.key   = k;
        it.last  = lst;
        it.pause = 1'b0;
        pending.push_back(it);
    endtask

    task automatic push_pause();
        load_item_t it;
        it.key   = '0;
        it.last  = 1'b0;
        it.pause = 1'b1;
        pending.push_back(it);
    endtask

    // a batch of n keys; negative spread means keys over the full range
    task automatic push_batch(input int n, input int spread);
        int base;
        int i;
        base = 0;
        if (spread >= 0)
            base = int'($urandom_range(NUM_BINS - 1 - spread)) - HALF_BINS;
        for (i = 1; i <= n; i++)
        begin
            if (spread < 0)
                push_key(KEY_BITS'($urandom), i == n);
            else
                push_key(KEY_BITS'(base + int'($urandom_range(spread))), i == n);
        end
    endtask

    // input and output monitor
    always @(posedge clk)
    begin
        key_fire <= keys_ch.valid && keys_ch.ready;
        if (rst_n)
        begin
            if (keys_ch.valid && keys_ch.ready)
                sort_predict(keys_ch.key, keys_ch.last);
            if (sorted_ch.valid && sorted_ch.ready)
            begin
                if (sorted_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected item: value %0d eob %0b dropped %0b",
                                         sorted_ch.sorted_value, sorted_ch.end_of_batch,
                                         sorted_ch.dropped));
                end
                else
                begin
                    sorted_item_t want;
                    want = sorted_due.pop_front();
                    if (sorted_ch.sorted_value !== want.value ||
                        sorted_ch.end_of_batch !== want.eob ||
                        sorted_ch.dropped !== want.dropped)
                        flag_error($sformatf(
                            "mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b (value/eob/dropped)",
                            want.value, want.eob, want.dropped, sorted_ch.sorted_value,
                            sorted_ch.end_of_batch, sorted_ch.dropped));
                end
            end
        end
    end

    // key driver
    always @(negedge clk)
    begin
        if (rst_n && !(keys_ch.valid && !key_fire))
        begin
            if (pending.size() != 0 && pending[0].pause)
            begin
                keys_ch.valid <= 1'b0;
                if (sorted_due.size() == 0)
                    void'(pending.pop_front());
            end
            else if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                keys_ch.key   <= pending[0].key;
                keys_ch.last  <= pending[0].last;
                keys_ch.valid <= 1'b1;
                void'(pending.pop_front());
            end
            else
            begin
                keys_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(negedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        sorted_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        int phase;
        int n;
        int sel;
        int fed;
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 66, 0, 23};
        recv_pct = '{0, 0, 66, 23};

        foreach (bin_count[i])
            bin_count[i] = '0;
        rst_n           = 1'b0;
        keys_ch.valid   = 1'b0;
        keys_ch.key     = '0;
        keys_ch.last    = 1'b0;
        sorted_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single extremes, full span, duplicates, around zero
        push_key(KEY_BITS'(-HALF_BINS), 1'b1);
        push_key(KEY_BITS'(HALF_BINS - 1), 1'b1);
        push_key(KEY_BITS'(HALF_BINS - 1), 1'b0);
        push_key(KEY_BITS'(-HALF_BINS), 1'b0);
        push_key(KEY_BITS'(0), 1'b0);
        push_key(KEY_BITS'(-1), 1'b1);
        push_key(KEY_BITS'(7), 1'b0);
        push_key(KEY_BITS'(7), 1'b0);
        push_key(KEY_BITS'(-3), 1'b0);
        push_key(KEY_BITS'(7), 1'b1);
        push_key(KEY_BITS'(1), 1'b0);
        push_key(KEY_BITS'(-1), 1'b0);
        push_key(KEY_BITS'(0), 1'b0);
        push_key(KEY_BITS'(-1), 1'b1);
        push_pause();
        while (pending.size() != 0)
            @(posedge clk);

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            fed = 0;
            if (phase == 0)
            begin
                // overflowing batch whose dropped key is the last one,
                // with the receiver held off so the block backs up
                hold_go = 1'b1;
                push_batch(MAX_ITEMS + 1, -1);
                fed += MAX_ITEMS;
            end
            while (fed < PHASE_KEYS)
            begin
                sel = $urandom_range(99);
                if (sel < 5)
                    n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
                else if (sel < 10)
                    n = MAX_ITEMS;
                else if (sel < 20)
                    n = 1;
                else
                    n = $urandom_range(2, 12);
                if ($urandom_range(9) == 0)
                    push_batch(n, -1);
                else
                    push_batch(n, $urandom_range(40));
                fed += (n > MAX_ITEMS) ? MAX_ITEMS : n;
                if ($urandom_range(7) == 0)
                    push_pause();
            end
            push_pause();
            while (pending.size() != 0)
                @(posedge clk);
        end

        // drain and watch for stray results
        while (keys_ch.valid || sorted_due.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ counting_sort_engine.f @@
rtl/core/cse_pkg.sv
rtl/core/cse_in_if.sv
rtl/core/cse_out_if.sv
rtl/core/cse_fifo.sv
rtl/core/cse_front.sv
rtl/core/cse_back.sv
rtl/core/counting_sort_engine.sv
tb/sv/counting_sort_engine_test.sv
